// File: sv/tlx_pkg.sv
// ----------------------------------------------------------------------------
// tlx_pkg
// shared types and constants of the token lexer with identifier table
// ----------------------------------------------------------------------------
package tlx_pkg;

	localparam int unsigned CODE_W = 31;
	localparam logic [CODE_W-1:0] CONST_MAX = 31'h7FFF_FFFF;

	// token kinds
	localparam logic [1:0] K_KEYWORD = 2'd0;
	localparam logic [1:0] K_IDENT   = 2'd1;
	localparam logic [1:0] K_CONST   = 2'd2;
	localparam logic [1:0] K_OP      = 2'd3;

	// keyword indexes
	localparam logic [CODE_W-1:0] KW_IF    = 31'd0;
	localparam logic [CODE_W-1:0] KW_ELSE  = 31'd1;
	localparam logic [CODE_W-1:0] KW_WHILE = 31'd2;

	// operator codes
	localparam logic [CODE_W-1:0] OP_LBRACE = 31'd3;
	localparam logic [CODE_W-1:0] OP_RBRACE = 31'd4;
	localparam logic [CODE_W-1:0] OP_SEMI   = 31'd6;
	localparam logic [CODE_W-1:0] OP_HASH   = 31'd8;
	localparam logic [CODE_W-1:0] OP_PLUS   = 31'd14;
	localparam logic [CODE_W-1:0] OP_STAR   = 31'd15;
	localparam logic [CODE_W-1:0] OP_ASSIGN = 31'd16;
	localparam logic [CODE_W-1:0] OP_AND    = 31'd17;
	localparam logic [CODE_W-1:0] OP_OR     = 31'd18;
	localparam logic [CODE_W-1:0] OP_NOT    = 31'd19;
	localparam logic [CODE_W-1:0] OP_REL    = 31'd20;
	localparam logic [CODE_W-1:0] OP_LPAREN = 31'd21;
	localparam logic [CODE_W-1:0] OP_RPAREN = 31'd22;

	// token request between front and back; word payload travels beside it
	typedef struct packed {
		logic              is_word;
		logic [1:0]        kind;
		logic [CODE_W-1:0] code;
		logic              ovf;
		logic              last;
	} tlx_cmd_t;

endpackage

// File: sv/tlx_in_if.sv
// ----------------------------------------------------------------------------
// tlx_in_if
// character channel: one byte and an end of text mark per request
// ----------------------------------------------------------------------------
interface tlx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_text;

	modport source (output valid, ch, end_of_text, input ready);
	modport sink (input valid, ch, end_of_text, output ready);
endinterface

// File: sv/tlx_out_if.sv
// ----------------------------------------------------------------------------
// tlx_out_if
// token channel: one token per request
// ----------------------------------------------------------------------------
interface tlx_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  token_kind;
	logic [30:0] token_code;
	logic        overflow;
	logic        last_of_run;

	modport source (output valid, token_kind, token_code, overflow, last_of_run,
		input ready);
	modport sink (input valid, token_kind, token_code, overflow, last_of_run,
		output ready);
endinterface

// File: sv/token_lexer_with_id_table.sv
// ----------------------------------------------------------------------------
// token_lexer_with_id_table
// streaming lexer with keyword detection and an identifier number table
// ----------------------------------------------------------------------------
//
// channel   dir  fields                                      meaning
// chars     in   ch[7:0], end_of_text                        one character
// tokens    out  token_kind[1:0], token_code[30:0],          one token
//                overflow, last_of_run
//
// a character is registered when taken and classified from that register;
// the scanner takes no new character until all its token requests are queued
// a name lookup reads the stored names one by one (one table read port),
// hidden behind the four-entry token queue
// reset empties the name table at once through its fill count
// either side may stall; the queue and the output register decouple them
//
module token_lexer_with_id_table
	import tlx_pkg::*;
#(
	parameter int unsigned MAX_NAME_LEN = 16,
	parameter int unsigned NAME_ENTRIES = 64
) (
	input logic        clk,
	input logic        arst_n,
	tlx_in_if.sink     chars,
	tlx_out_if.source  tokens
);
	// width of a name length, able to hold the full length
	localparam int unsigned LW = $clog2(MAX_NAME_LEN + 1);
	localparam int unsigned QW = $bits(tlx_cmd_t) + MAX_NAME_LEN * 8 + LW + 1;

	// scanner side of the queue
	logic                      f_push;
	tlx_cmd_t                  f_cmd;
	logic [MAX_NAME_LEN*8-1:0] f_word;
	logic [LW-1:0]             f_len;
	logic                      f_trunc;
	logic                      q_full;

	// back end side of the queue
	logic          q_valid;
	logic          q_pop;
	logic [QW-1:0] q_head;

	tlx_front #(
		.MAX_NAME_LEN (MAX_NAME_LEN),
		.LW           (LW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push       (f_push),
		.push_cmd   (f_cmd),
		.push_word  (f_word),
		.push_len   (f_len),
		.push_trunc (f_trunc),
		.q_full     (q_full)
	);

	// token requests with the word that goes with them
	tlx_queue #(
		.WIDTH (QW),
		.DEPTH (4)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_cmd, f_word, f_len, f_trunc}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	tlx_back #(
		.MAX_NAME_LEN (MAX_NAME_LEN),
		.NAME_ENTRIES (NAME_ENTRIES),
		.LW           (LW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (tlx_cmd_t'(q_head[QW-1 -: $bits(tlx_cmd_t)])),
		.q_word  (q_head[LW+1 +: MAX_NAME_LEN*8]),
		.q_len   (q_head[1 +: LW]),
		.q_trunc (q_head[0]),
		.pop     (q_pop),
		.tokens  (tokens)
	);
endmodule

// File: sv/tlx_queue.sv
// ----------------------------------------------------------------------------
// tlx_queue
// small register queue between the scanner and the token back end
// ----------------------------------------------------------------------------
module tlx_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push && !full) - CW'(pop && not_empty);
		end
	end
endmodule

// File: sv/tlx_front.sv
// ----------------------------------------------------------------------------
// tlx_front
// scanner: classifies characters by maximal munch and queues token requests
// ----------------------------------------------------------------------------
module tlx_front
	import tlx_pkg::*;
#(
	parameter int unsigned MAX_NAME_LEN = 16,
	parameter int unsigned LW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	tlx_in_if.sink                    chars,
	output logic                      push,
	output tlx_cmd_t                  push_cmd,
	output logic [MAX_NAME_LEN*8-1:0] push_word,
	output logic [LW-1:0]             push_len,
	output logic                      push_trunc,
	input  logic                      q_full
);
	localparam int unsigned IW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

	typedef enum logic [2:0] {
		M_IDLE, M_WORD, M_NUM, M_EQ, M_AMP, M_BAR, M_REL
	} mode_t;

	mode_t             mode_q;
	logic [7:0]        word_q [MAX_NAME_LEN];
	logic [LW-1:0]     wlen_q;
	logic              wtrunc_q;
	logic [CODE_W-1:0] num_q;
	logic              nsat_q;

	logic       hold_q;
	logic [7:0] ch_q;
	logic       eot_q;
	logic       idx_q;

	// next state and requests of the held character
	mode_t             m;
	logic [7:0]        w [MAX_NAME_LEN];
	logic [LW-1:0]     wl;
	logic              wt;
	logic [CODE_W-1:0] nv;
	logic              ns;
	logic [1:0]        n;
	tlx_cmd_t          ev [2];
	logic [7:0]        pw [MAX_NAME_LEN];
	logic [LW-1:0]     pl;
	logic              pt;
	logic              done;
	logic              is_let, is_dig;
	logic [3:0]        d;
	logic [CODE_W+3:0] prod;

	assign is_let = (ch_q >= "a" && ch_q <= "z") || (ch_q >= "A" && ch_q <= "Z") ||
		ch_q == "-" || ch_q == "_";
	assign is_dig = (ch_q >= "0" && ch_q <= "9");
	assign d      = ch_q[3:0];

	always_comb begin
		m    = mode_q;
		w    = word_q;
		wl   = wlen_q;
		wt   = wtrunc_q;
		nv   = num_q;
		ns   = nsat_q;
		n    = '0;
		ev[0] = '0;
		ev[1] = '0;
		pw   = word_q;
		pl   = wlen_q;
		pt   = wtrunc_q;
		done = 1'b0;
		prod = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + (CODE_W + 4)'(d);

		// continuation of the pending token
		unique case (mode_q)
			M_WORD: begin
				if (is_let || is_dig) begin
					if (wl < LW'(MAX_NAME_LEN)) begin
						w[wl[IW-1:0]] = ch_q;
						wl = wl + 1'b1;
					end else begin
						wt = 1'b1;
					end
					done = 1'b1;
				end else begin
					ev[n[0]] = '{is_word: 1'b1, kind: K_IDENT, code: '0, ovf: wt, last: 1'b0};
					pw = w; pl = wl; pt = wt;
					n = n + 1'b1;
				end
			end
			M_NUM: begin
				if (is_dig) begin
					if (prod > (CODE_W + 4)'(CONST_MAX)) begin
						nv = CONST_MAX;
						ns = 1'b1;
					end else begin
						nv = prod[CODE_W-1:0];
					end
					done = 1'b1;
				end else begin
					ev[n[0]] = '{is_word: 1'b0, kind: K_CONST, code: nv, ovf: ns, last: 1'b0};
					n = n + 1'b1;
				end
			end
			M_EQ: begin
				if (ch_q == "=") begin
					ev[n[0]] = '{1'b0, K_OP, OP_REL, 1'b0, 1'b0};
					m = M_IDLE;
					done = 1'b1;
				end else begin
					ev[n[0]] = '{1'b0, K_OP, OP_ASSIGN, 1'b0, 1'b0};
				end
				n = n + 1'b1;
			end
			M_AMP: begin
				if (ch_q == "&") begin
					ev[n[0]] = '{1'b0, K_OP, OP_AND, 1'b0, 1'b0};
					n = n + 1'b1;
					m = M_IDLE;
					done = 1'b1;
				end
			end
			M_BAR: begin
				if (ch_q == "|") begin
					ev[n[0]] = '{1'b0, K_OP, OP_OR, 1'b0, 1'b0};
					n = n + 1'b1;
					m = M_IDLE;
					done = 1'b1;
				end
			end
			M_REL: begin
				ev[n[0]] = '{1'b0, K_OP, OP_REL, 1'b0, 1'b0};
				n = n + 1'b1;
				if (ch_q == "=") begin
					m = M_IDLE;
					done = 1'b1;
				end
			end
			default: ;
		endcase

		// character starts something new
		if (!done) begin
			m = M_IDLE;
			if (is_let) begin
				m = M_WORD;
				w[0] = ch_q;
				wl = LW'(1);
				wt = 1'b0;
			end else if (is_dig) begin
				m = M_NUM;
				nv = CODE_W'(d);
				ns = 1'b0;
			end else begin
				unique case (ch_q) inside
					"{": begin ev[n[0]] = '{1'b0, K_OP, OP_LBRACE, 1'b0, 1'b0}; n = n + 1'b1; end
					"}": begin ev[n[0]] = '{1'b0, K_OP, OP_RBRACE, 1'b0, 1'b0}; n = n + 1'b1; end
					";": begin ev[n[0]] = '{1'b0, K_OP, OP_SEMI, 1'b0, 1'b0}; n = n + 1'b1; end
					"#": begin ev[n[0]] = '{1'b0, K_OP, OP_HASH, 1'b0, 1'b0}; n = n + 1'b1; end
					"+": begin ev[n[0]] = '{1'b0, K_OP, OP_PLUS, 1'b0, 1'b0}; n = n + 1'b1; end
					"*": begin ev[n[0]] = '{1'b0, K_OP, OP_STAR, 1'b0, 1'b0}; n = n + 1'b1; end
					"!": begin ev[n[0]] = '{1'b0, K_OP, OP_NOT, 1'b0, 1'b0}; n = n + 1'b1; end
					"(": begin ev[n[0]] = '{1'b0, K_OP, OP_LPAREN, 1'b0, 1'b0}; n = n + 1'b1; end
					")": begin ev[n[0]] = '{1'b0, K_OP, OP_RPAREN, 1'b0, 1'b0}; n = n + 1'b1; end
					"=": m = M_EQ;
					"&": m = M_AMP;
					"|": m = M_BAR;
					"<", ">": m = M_REL;
					default: ;
				endcase
			end
		end

		// end of text flushes a pending word, constant or '='; a lone '&' '|' '<' '>' drops
		if (eot_q) begin
			if (m == M_WORD) begin
				ev[n[0]] = '{is_word: 1'b1, kind: K_IDENT, code: '0, ovf: wt, last: 1'b0};
				pw = w; pl = wl; pt = wt;
				n = n + 1'b1;
			end else if (m == M_NUM) begin
				ev[n[0]] = '{is_word: 1'b0, kind: K_CONST, code: nv, ovf: ns, last: 1'b0};
				n = n + 1'b1;
			end else if (m == M_EQ) begin
				ev[n[0]] = '{1'b0, K_OP, OP_ASSIGN, 1'b0, 1'b0};
				n = n + 1'b1;
			end
			m  = M_IDLE;
			wl = '0;
			wt = 1'b0;
			nv = '0;
			ns = 1'b0;
		end
	end

	logic commit;

	assign chars.ready = !hold_q;
	assign push        = hold_q && (n != '0) && !q_full;
	assign commit      = hold_q && ((n == '0) || (push && ({1'b0, idx_q} == n - 1'b1)));

	always_comb begin
		push_cmd      = ev[idx_q];
		push_cmd.last = ({1'b0, idx_q} == n - 1'b1);
		for (int i = 0; i < MAX_NAME_LEN; i++) begin
			push_word[i*8 +: 8] = pw[i];
		end
		push_len   = pl;
		push_trunc = pt;
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_q  <= chars.ch;
			eot_q <= chars.end_of_text;
		end
		if (commit) begin
			word_q <= w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= 1'b0;
			idx_q    <= 1'b0;
			mode_q   <= M_IDLE;
			wlen_q   <= '0;
			wtrunc_q <= 1'b0;
			num_q    <= '0;
			nsat_q   <= 1'b0;
		end else begin
			if (chars.valid && chars.ready) begin
				hold_q <= 1'b1;
			end
			if (commit) begin
				hold_q   <= 1'b0;
				idx_q    <= 1'b0;
				mode_q   <= m;
				wlen_q   <= wl;
				wtrunc_q <= wt;
				num_q    <= nv;
				nsat_q   <= ns;
			end else if (push) begin
				idx_q <= 1'b1;
			end
		end
	end
endmodule

// File: sv/tlx_back.sv
// ----------------------------------------------------------------------------
// tlx_back
// token back end: keyword check, name table search and insert, output register
// ----------------------------------------------------------------------------
module tlx_back
	import tlx_pkg::*;
#(
	parameter int unsigned MAX_NAME_LEN = 16,
	parameter int unsigned NAME_ENTRIES = 64,
	parameter int unsigned LW = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  tlx_cmd_t                  q_cmd,
	input  logic [MAX_NAME_LEN*8-1:0] q_word,
	input  logic [LW-1:0]             q_len,
	input  logic                      q_trunc,
	output logic                      pop,
	tlx_out_if.source                 tokens
);
	localparam int unsigned IW = (NAME_ENTRIES > 1) ? $clog2(NAME_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(NAME_ENTRIES + 1);
	localparam int unsigned RW = MAX_NAME_LEN * 8 + LW;

	typedef enum logic {B_IDLE, B_SEARCH} bstate_t;

	logic [RW-1:0] table_mem [NAME_ENTRIES];
	logic [RW-1:0] rdata_q;

	bstate_t           state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     addr_q;
	logic [IW-1:0]     ridx_q;
	logic              rv_q;
	logic              ov_q;
	logic [1:0]        kind_q;
	logic [CODE_W-1:0] code_q;
	logic              ovf_q;
	logic              last_q;

	logic              can_out;
	logic              kw_hit;
	logic [CODE_W-1:0] kw_code;
	logic              match;
	logic              tbl_full;
	logic              last_entry;

	assign can_out    = !ov_q || tokens.ready;
	assign tbl_full   = (count_q == CW'(NAME_ENTRIES));
	assign last_entry = (CW'(ridx_q) == count_q - 1'b1);

	always_comb begin
		kw_hit  = 1'b0;
		kw_code = KW_IF;
		if (!q_trunc && q_len == LW'(2) && q_word[7:0] == "i" && q_word[15:8] == "f") begin
			kw_hit = 1'b1;
		end else if (!q_trunc && q_len == LW'(4) && q_word[7:0] == "e" &&
				q_word[15:8] == "l" && q_word[23:16] == "s" && q_word[31:24] == "e") begin
			kw_hit  = 1'b1;
			kw_code = KW_ELSE;
		end else if (!q_trunc && q_len == LW'(5) && q_word[7:0] == "w" &&
				q_word[15:8] == "h" && q_word[23:16] == "i" && q_word[31:24] == "l" &&
				q_word[39:32] == "e") begin
			kw_hit  = 1'b1;
			kw_code = KW_WHILE;
		end
	end

	// stored row holds length over characters
	always_comb begin
		match = (rdata_q[RW-1 -: LW] == q_len);
		for (int i = 0; i < MAX_NAME_LEN; i++) begin
			if (LW'(i) < q_len && rdata_q[i*8 +: 8] != q_word[i*8 +: 8]) begin
				match = 1'b0;
			end
		end
	end

	logic do_new, do_read, load;
	logic [1:0]        ld_kind;
	logic [CODE_W-1:0] ld_code;
	logic              ld_ovf;

	always_comb begin
		do_new  = 1'b0;
		do_read = 1'b0;
		load    = 1'b0;
		pop     = 1'b0;
		ld_kind = q_cmd.kind;
		ld_code = q_cmd.code;
		ld_ovf  = q_cmd.ovf;
		if (q_valid && can_out) begin
			unique case (state_q)
				B_IDLE: begin
					if (!q_cmd.is_word) begin
						load = 1'b1;
						pop  = 1'b1;
					end else if (kw_hit) begin
						load    = 1'b1;
						pop     = 1'b1;
						ld_kind = K_KEYWORD;
						ld_code = kw_code;
						ld_ovf  = 1'b0;
					end else if (count_q == '0) begin
						do_new = 1'b1;
					end
				end
				B_SEARCH: begin
					if (rv_q && match) begin
						load    = 1'b1;
						pop     = 1'b1;
						ld_kind = K_IDENT;
						ld_code = CODE_W'(ridx_q);
						ld_ovf  = q_trunc;
					end else if (rv_q && last_entry) begin
						do_new = 1'b1;
					end else begin
						do_read = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (do_new) begin
			load    = 1'b1;
			pop     = 1'b1;
			ld_kind = K_IDENT;
			ld_code = tbl_full ? '0 : CODE_W'(count_q);
			ld_ovf  = tbl_full ? 1'b1 : q_trunc;
		end
	end

	always_ff @(posedge clk) begin
		if (do_new && !tbl_full) begin
			table_mem[count_q[IW-1:0]] <= {q_len, q_word};
		end
		if (do_read) begin
			rdata_q <= table_mem[addr_q[IW-1:0]];
		end
		if (load) begin
			kind_q <= ld_kind;
			code_q <= ld_code;
			ovf_q  <= ld_ovf;
			last_q <= q_cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			addr_q  <= '0;
			ridx_q  <= '0;
			rv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (tokens.ready) begin
				ov_q <= 1'b0;
			end
			if (do_new && !tbl_full) begin
				count_q <= count_q + 1'b1;
			end
			if (load) begin
				state_q <= B_IDLE;
			end else if (state_q == B_IDLE && q_valid && can_out) begin
				state_q <= B_SEARCH;
				addr_q  <= '0;
				rv_q    <= 1'b0;
			end
			if (do_read) begin
				rv_q   <= 1'b1;
				ridx_q <= addr_q[IW-1:0];
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	assign tokens.valid       = ov_q;
	assign tokens.token_kind  = kind_q;
	assign tokens.token_code  = code_q;
	assign tokens.overflow    = ovf_q;
	assign tokens.last_of_run = last_q;
endmodule

// File: sim/token_lexer_with_id_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_lexer_with_id_table_test
// self-checking bench: character stream in, predicted tokens compared out
// ----------------------------------------------------------------------------
module token_lexer_with_id_table_test;
	import tlx_pkg::*;

	localparam int NAME_LEN = 16;
	localparam int TABLE_SIZE = 64;
	localparam int RANDOM_ITEMS = 1100;

	// scanner modes of the predictor
	typedef enum int {S_IDLE, S_WORD, S_NUM, S_EQ, S_AMP, S_BAR, S_REL} scan_t;

	typedef struct {
		logic [1:0]  kind;
		logic [30:0] code;
		logic        ovf;
		logic        last;
	} token_t;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
		int         phase;
	} char_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlx_in_if chars ();
	tlx_out_if tokens ();

	token_lexer_with_id_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	always #10 clk = ~clk;

	// predictor state
	scan_t       mode;
	logic [7:0]  word_buf [NAME_LEN];
	int          word_len;
	bit          word_trunc;
	int unsigned num_val;
	bit          num_sat;
	logic [7:0]  names [TABLE_SIZE][NAME_LEN];
	int          name_lens [TABLE_SIZE];
	int          name_cnt;

	token_t    step_toks [$];
	token_t    expected_tokens [$];
	char_req_t pending_chars [$];
	string     name_pool [$];

	int mismatches = 0;
	int chars_sent = 0;
	int tokens_seen = 0;
	int cur_phase = 0;
	int src_pct = 0;
	int snk_pct = 0;
	bit in_took = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "-" || c == "_";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void push_tok(logic [1:0] k, logic [30:0] code, bit ovf);
		token_t t;
		t.kind = k;
		t.code = code;
		t.ovf = ovf;
		t.last = 1'b0;
		if (step_toks.size() < 2)
			step_toks.insert(step_toks.size(), t);
	endfunction

	function automatic bit word_matches(string kw);
		if (word_trunc || word_len != kw.len())
			return 0;
		for (int i = 0; i < kw.len(); i++)
			if (word_buf[i] != kw[i])
				return 0;
		return 1;
	endfunction

	// finish an identifier: keyword, known name, new name or table full
	function automatic void close_word();
		bit hit;
		if (word_matches("if")) begin
			push_tok(K_KEYWORD, KW_IF, 0);
			return;
		end
		if (word_matches("else")) begin
			push_tok(K_KEYWORD, KW_ELSE, 0);
			return;
		end
		if (word_matches("while")) begin
			push_tok(K_KEYWORD, KW_WHILE, 0);
			return;
		end
		for (int e = 0; e < name_cnt; e++) begin
			hit = (name_lens[e] == word_len);
			for (int i = 0; i < word_len; i++)
				if (names[e][i] != word_buf[i])
					hit = 0;
			if (hit) begin
				push_tok(K_IDENT, 31'(e), word_trunc);
				return;
			end
		end
		if (name_cnt >= TABLE_SIZE) begin
			push_tok(K_IDENT, 31'd0, 1);
			return;
		end
		for (int i = 0; i < word_len; i++)
			names[name_cnt][i] = word_buf[i];
		name_lens[name_cnt] = word_len;
		push_tok(K_IDENT, 31'(name_cnt), word_trunc);
		name_cnt++;
	endfunction

	function automatic void start_token(logic [7:0] c);
		mode = S_IDLE;
		if (is_letter(c)) begin
			mode = S_WORD;
			word_buf[0] = c;
			word_len = 1;
			word_trunc = 0;
		end else if (is_digit(c)) begin
			mode = S_NUM;
			num_val = c - "0";
			num_sat = 0;
		end else begin
			case (c)
				"{": push_tok(K_OP, OP_LBRACE, 0);
				"}": push_tok(K_OP, OP_RBRACE, 0);
				";": push_tok(K_OP, OP_SEMI, 0);
				"#": push_tok(K_OP, OP_HASH, 0);
				"+": push_tok(K_OP, OP_PLUS, 0);
				"*": push_tok(K_OP, OP_STAR, 0);
				"!": push_tok(K_OP, OP_NOT, 0);
				"(": push_tok(K_OP, OP_LPAREN, 0);
				")": push_tok(K_OP, OP_RPAREN, 0);
				"=": mode = S_EQ;
				"&": mode = S_AMP;
				"|": mode = S_BAR;
				"<", ">": mode = S_REL;
				default: ;
			endcase
		end
	endfunction

	// one character through the scanner, with one character of lookahead
	function automatic void scan_char(logic [7:0] c);
		int unsigned d;
		case (mode)
			S_WORD: begin
				if (is_letter(c) || is_digit(c)) begin
					if (word_len < NAME_LEN)
						word_buf[word_len++] = c;
					else
						word_trunc = 1;
					return;
				end
				close_word();
			end
			S_NUM: begin
				if (is_digit(c)) begin
					d = c - "0";
					if (num_val > (32'h7FFF_FFFF - d) / 10) begin
						num_val = 32'h7FFF_FFFF;
						num_sat = 1;
					end else
						num_val = num_val * 10 + d;
					return;
				end
				push_tok(K_CONST, num_val[30:0], num_sat);
			end
			S_EQ: begin
				if (c == "=") begin
					push_tok(K_OP, OP_REL, 0);
					mode = S_IDLE;
					return;
				end
				push_tok(K_OP, OP_ASSIGN, 0);
			end
			S_AMP: if (c == "&") begin
				push_tok(K_OP, OP_AND, 0);
				mode = S_IDLE;
				return;
			end
			S_BAR: if (c == "|") begin
				push_tok(K_OP, OP_OR, 0);
				mode = S_IDLE;
				return;
			end
			S_REL: begin
				push_tok(K_OP, OP_REL, 0);
				if (c == "=") begin
					mode = S_IDLE;
					return;
				end
			end
			default: ;
		endcase
		start_token(c);
	endfunction

	// expected tokens for one accepted character request
	function automatic void predict_tokens(logic [7:0] c, logic eot);
		token_t t;
		step_toks.delete();
		scan_char(c);
		if (eot) begin
			// pending word, constant or '=' is flushed; lone '&' '|' '<' '>' drop
			if (mode == S_WORD)
				close_word();
			else if (mode == S_NUM)
				push_tok(K_CONST, num_val[30:0], num_sat);
			else if (mode == S_EQ)
				push_tok(K_OP, OP_ASSIGN, 0);
			mode = S_IDLE;
			word_len = 0;
			word_trunc = 0;
			num_val = 0;
			num_sat = 0;
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size()-1].last = 1'b1;
		foreach (step_toks[i]) begin
			t = step_toks[i];
			expected_tokens.insert(expected_tokens.size(), t);
		end
	endfunction

	// stimulus building
	task automatic queue_text(string s, int phase, bit eot_at_end);
		char_req_t r;
		for (int i = 0; i < s.len(); i++) begin
			r.ch = s[i];
			r.eot = eot_at_end && (i == s.len() - 1);
			r.phase = phase;
			pending_chars.insert(pending_chars.size(), r);
		end
	endtask

	function automatic string random_name(int n);
		string s;
		string first_set;
		string rest_set;
		first_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_";
		rest_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-_0123456789";
		s = "";
		s = {s, string'(first_set[$urandom_range(0, first_set.len()-1)])};
		for (int i = 1; i < n; i++)
			s = {s, string'(rest_set[$urandom_range(0, rest_set.len()-1)])};
		return s;
	endfunction

	function automatic string random_number(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	// one well-formed program fragment with random content, sometimes noisy
	task automatic queue_fragment(int phase);
		string ops [19] = '{"{", "}", ";", "#", "+", "*", "!", "(", ")", "=", "==",
			"&&", "||", "<", "<=", ">", ">=", "&", "|"};
		string kws [3] = '{"if", "else", "while"};
		string s;
		string tok;
		int n;
		int pick;
		char_req_t r;
		n = $urandom_range(1, 8);
		s = "";
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				if (name_pool.size() > 0 && $urandom_range(0, 1))
					tok = name_pool[$urandom_range(0, name_pool.size()-1)];
				else begin
					tok = random_name($urandom_range(1, 6));
					name_pool.insert(name_pool.size(), tok);
				end
			end else if (pick < 33)
				tok = random_name($urandom_range(17, 20));
			else if (pick < 43)
				tok = kws[$urandom_range(0, 2)];
			else if (pick < 55)
				tok = random_number($urandom_range(1, 4));
			else if (pick < 58)
				tok = random_number($urandom_range(10, 12));
			else
				tok = ops[$urandom_range(0, 18)];
			s = {s, tok};
			if ($urandom_range(0, 2) == 0)
				s = {s, " "};
		end
		queue_text(s, phase, 1);
		// noise: raw bytes with stray end marks
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				r.ch = 8'($urandom_range(0, 255));
				r.eot = ($urandom_range(0, 3) == 0);
				r.phase = phase;
				pending_chars.insert(pending_chars.size(), r);
			end
		end
	endtask

	// sender: offers the head of the queue, idling at the phase's rate
	always @(negedge clk) begin
		if (!arst_n) begin
			chars.valid <= 1'b0;
		end else if (in_took || !chars.valid) begin
			if (pending_chars.size() > 0) begin
				cur_phase = pending_chars[0].phase;
				case (cur_phase)
					0: begin src_pct = 0; snk_pct = 0; end
					1: begin src_pct = 80; snk_pct = 0; end
					2: begin src_pct = 0; snk_pct = 80; end
					default: begin src_pct = 8; snk_pct = 8; end
				endcase
			end
			if (pending_chars.size() > 0 && $urandom_range(0, 99) >= src_pct) begin
				chars.ch <= pending_chars[0].ch;
				chars.end_of_text <= pending_chars[0].eot;
				chars.valid <= 1'b1;
				void'(pending_chars.pop_front());
			end else begin
				chars.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off so the input backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			tokens.ready <= 1'b0;
		end else begin
			if (!hold_done && hold_cnt == 0 && chars_sent >= 500)
				hold_cnt = 400;
			if (hold_cnt > 0) begin
				hold_cnt--;
				if (hold_cnt == 0)
					hold_done = 1'b1;
				tokens.ready <= 1'b0;
			end else begin
				tokens.ready <= ($urandom_range(0, 99) >= snk_pct);
			end
		end
	end

	// sampling at the rising edge: predict on accepted characters, check tokens
	always @(posedge clk) begin
		token_t want;
		in_took = arst_n && chars.valid && chars.ready;
		if (in_took) begin
			predict_tokens(chars.ch, chars.end_of_text);
			chars_sent++;
		end
		if (arst_n && tokens.valid && tokens.ready) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token kind %0d code %0d ovf %0b last %0b",
						tokens.token_kind, tokens.token_code, tokens.overflow,
						tokens.last_of_run);
			end else begin
				want = expected_tokens.pop_front();
				if (tokens.token_kind !== want.kind || tokens.token_code !== want.code ||
					tokens.overflow !== want.ovf || tokens.last_of_run !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("token %0d: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
							tokens_seen, want.kind, want.code, want.ovf, want.last,
							tokens.token_kind, tokens.token_code, tokens.overflow,
							tokens.last_of_run);
				end
			end
		end
	end

	// run limit
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int phase;
		chars.valid = 1'b0;
		chars.ch = 8'd0;
		chars.end_of_text = 1'b0;
		tokens.ready = 1'b0;
		mode = S_IDLE;
		word_len = 0;
		word_trunc = 0;
		num_val = 0;
		num_sat = 0;
		name_cnt = 0;

		// directed: every operator, keywords, '=' flushed at end, lone '&'
		queue_text("if(ab<=9)&&c||d>=e!{}; #+*&x==y<z=", 0, 1);
		queue_text("w&", 0, 1);
		queue_text("else while 2147483648", 0, 1);

		// random fragments across the idling phases
		while (pending_chars.size() < RANDOM_ITEMS + 60) begin
			phase = (pending_chars.size() * 4) / (RANDOM_ITEMS + 60);
			queue_fragment(phase);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_chars.size() == 0 && !chars.valid && expected_tokens.size() == 0);
		repeat (100) @(posedge clk);

		$display("covered %0d characters and %0d tokens, %0d names in the table",
			chars_sent, tokens_seen, name_cnt);
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d tokens missing", mismatches, expected_tokens.size());
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

// File: token_lexer_with_id_table.f
sv/tlx_pkg.sv
sv/tlx_in_if.sv
sv/tlx_out_if.sv
sv/tlx_queue.sv
sv/tlx_front.sv
sv/tlx_back.sv
sv/token_lexer_with_id_table.sv
sim/token_lexer_with_id_table_test.sv
